@@ hdl/olrb_pkg.sv @@
// Shared types and operation codes for the overwriting log ring buffer.
`default_nettype none

package olrb_pkg;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_READ   = 2'd1,
    MODE_REWIND = 2'd2,
    MODE_POP    = 2'd3
  } mode_t;

  // Control from the pointer unit to the byte store and the result stage.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic dropped;
  } mem_ctl_t;

endpackage

`default_nettype wire

@@ hdl/overwriting_log_ring_buffer.sv @@
// Top level of the overwriting log ring buffer.
//
// A command word (mode, data_byte) is taken at a rising edge where start is
// high and busy is low. Mode 0 appends a byte, dropping the oldest one when
// the ring already holds DEPTH-1 bytes; mode 1 reads at the cursor and
// advances it; mode 2 rewinds the cursor to the oldest byte; mode 3 pops the
// oldest byte.
// Every command gives one result word: done is high for exactly one cycle,
// in the cycle after the command was taken, with read_byte, read_valid and
// dropped_oldest valid in that cycle. The receiver cannot stall the block.
// Each command makes at most one access to the single-port byte store, so busy
// stays low and a command may be issued every cycle: throughput one command
// per cycle.
// Reset clears the three pointers, leaving the ring empty; the byte store
// itself is not cleared and no clearing pass is needed, since only entries
// already written can be read.
`default_nettype none

module overwriting_log_ring_buffer #(
  parameter int DEPTH = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] mode,
  input  wire logic [7:0] data_byte,
  output logic            done,
  output logic      [7:0] read_byte,
  output logic            read_valid,
  output logic            dropped_oldest
);

  import olrb_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic          accept;
  logic [AW-1:0] addr;
  mem_ctl_t      ctl;
  logic [7:0]    rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  olrb_ptr #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ptr (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .mode   (mode),
    .addr   (addr),
    .ctl    (ctl)
  );

  olrb_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .wr_en (ctl.wr_en),
    .rd_en (ctl.rd_en),
    .addr  (addr),
    .wdata (data_byte),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done           <= 1'b0;
      read_valid     <= 1'b0;
      dropped_oldest <= 1'b0;
    end else begin
      done           <= accept;
      read_valid     <= ctl.rd_en;
      dropped_oldest <= ctl.dropped;
    end
  end

  // Read data is only shown when the word actually returned a byte.
  assign read_byte = read_valid ? rdata : 8'd0;

`ifndef ASSERT_OFF
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept))
    else $error("done without an accepted command word");

  a_valid_needs_done: assert property (@(posedge clk) disable iff (rst)
    read_valid |-> done)
    else $error("read_valid outside a result word");

  a_drop_needs_done: assert property (@(posedge clk) disable iff (rst)
    dropped_oldest |-> done)
    else $error("dropped_oldest outside a result word");

  a_no_read_and_drop: assert property (@(posedge clk) disable iff (rst)
    !(read_valid && dropped_oldest))
    else $error("a word both returned a byte and dropped one");

  a_store_one_access: assert property (@(posedge clk) disable iff (rst)
    !(ctl.wr_en && ctl.rd_en))
    else $error("byte store written and read in the same cycle");
`endif

endmodule

`default_nettype wire

@@ hdl/olrb_mem.sv @@
// Byte store of the ring: one write or one read per cycle, registered read data.
`default_nettype none

module olrb_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] addr,
  input  wire logic [7:0]    wdata,
  output logic      [7:0]    rdata
);

  logic [7:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= store[addr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/olrb_ptr.sv @@
// Pointer unit: write, oldest and cursor pointers and the store access per word.
`default_nettype none

module olrb_ptr #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [1:0]        mode,
  output logic      [AW-1:0]     addr,
  output olrb_pkg::mem_ctl_t     ctl
);

  import olrb_pkg::*;

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0] write_pos, oldest_pos, cursor_pos;
  logic [AW-1:0] write_pos_next, oldest_pos_next, cursor_pos_next;
  logic [AW-1:0] write_inc, oldest_inc, cursor_inc;
  logic          full;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    ring_next = (p == LAST) ? '0 : p + AW'(1);
  endfunction

  assign write_inc  = ring_next(write_pos);
  assign oldest_inc = ring_next(oldest_pos);
  assign cursor_inc = ring_next(cursor_pos);
  assign full       = (write_inc == oldest_pos);

  always_comb begin
    write_pos_next  = write_pos;
    oldest_pos_next = oldest_pos;
    cursor_pos_next = cursor_pos;
    addr            = write_pos;
    ctl             = '0;
    if (accept) begin
      case (mode_t'(mode))
        MODE_APPEND: begin
          // A full ring drops its oldest byte; a cursor parked on it follows.
          if (full) begin
            oldest_pos_next = oldest_inc;
            ctl.dropped     = 1'b1;
            if (cursor_pos == oldest_pos) begin
              cursor_pos_next = oldest_inc;
            end
          end
          ctl.wr_en      = 1'b1;
          addr           = write_pos;
          write_pos_next = write_inc;
        end
        MODE_READ: begin
          addr = cursor_pos;
          if (cursor_pos != write_pos) begin
            ctl.rd_en       = 1'b1;
            cursor_pos_next = cursor_inc;
          end
        end
        MODE_REWIND: begin
          cursor_pos_next = oldest_pos;
        end
        MODE_POP: begin
          addr = oldest_pos;
          if (oldest_pos != write_pos) begin
            ctl.rd_en       = 1'b1;
            oldest_pos_next = oldest_inc;
          end
        end
        default: begin
          ctl = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos  <= '0;
      oldest_pos <= '0;
      cursor_pos <= '0;
    end else begin
      write_pos  <= write_pos_next;
      oldest_pos <= oldest_pos_next;
      cursor_pos <= cursor_pos_next;
    end
  end

endmodule

`default_nettype wire

@@ verif/tb_overwriting_log_ring_buffer.sv @@
// Self-checking testbench for the overwriting log ring buffer: queued commands, shadow ring.
module tb_overwriting_log_ring_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  import olrb_pkg::*;

  localparam int RING_DEPTH = 1024;
  localparam int FILL_APPENDS = 1030;
  localparam int MIXED_WORDS = 110;

  typedef struct {
    mode_t      op;
    logic [7:0] value;
  } log_cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       dropped;
  } ring_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [1:0] mode = 2'd0;
  logic [7:0] data_byte = 8'd0;
  logic       busy;
  logic       done;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       dropped_oldest;

  log_cmd_t     cmd_queue[$];
  ring_result_t expected_results[$];
  int           total_words;
  int           issued_words = 0;
  int           error_count = 0;
  bit           word_taken = 1'b0;

  // Shadow copy of the ring.
  logic [7:0] shadow_bytes [RING_DEPTH];
  int         wr_ptr = 0;
  int         old_ptr = 0;
  int         rd_cursor = 0;

  overwriting_log_ring_buffer #(.DEPTH(RING_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .data_byte(data_byte),
    .done(done),
    .read_byte(read_byte),
    .read_valid(read_valid),
    .dropped_oldest(dropped_oldest)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int step_pos(int p);
    return (p + 1) % RING_DEPTH;
  endfunction

  function automatic ring_result_t log_ring_apply(mode_t op, logic [7:0] value);
    ring_result_t r;
    r = '{data: 8'd0, valid: 1'b0, dropped: 1'b0};
    case (op)
      MODE_APPEND: begin
        if (step_pos(wr_ptr) == old_ptr) begin
          old_ptr = step_pos(old_ptr);
          // The cursor is dragged along only if it sat on the dropped byte.
          if (step_pos(rd_cursor) == old_ptr) rd_cursor = old_ptr;
          r.dropped = 1'b1;
        end
        shadow_bytes[wr_ptr] = value;
        wr_ptr = step_pos(wr_ptr);
      end
      MODE_READ: begin
        if (rd_cursor != wr_ptr) begin
          r.data = shadow_bytes[rd_cursor];
          r.valid = 1'b1;
          rd_cursor = step_pos(rd_cursor);
        end
      end
      MODE_REWIND: begin
        rd_cursor = old_ptr;
      end
      default: begin
        if (old_ptr != wr_ptr) begin
          r.data = shadow_bytes[old_ptr];
          r.valid = 1'b1;
          old_ptr = step_pos(old_ptr);
        end
      end
    endcase
    return r;
  endfunction

  function automatic void push_cmd(mode_t op, logic [7:0] value);
    log_cmd_t c;
    c.op = op;
    c.value = value;
    cmd_queue.push_back(c);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void report_mismatch(string field, int want, int got);
    error_count++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
  endfunction

  // Driver: a new word goes out once the previous one was taken.
  always @(negedge clk) begin
    log_cmd_t c;
    int idle_pct;
    if (rst) begin
      start <= 1'b0;
      mode <= MODE_APPEND;
      data_byte <= 8'd0;
    end else if (!start || word_taken) begin
      if (issued_words < total_words / 3) idle_pct = 12;
      else if (issued_words < 2 * total_words / 3) idle_pct = 54;
      else idle_pct = 0;
      if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        c = cmd_queue.pop_front();
        start <= 1'b1;
        mode <= c.op;
        data_byte <= c.value;
        issued_words++;
      end else begin
        start <= 1'b0;
        mode <= 2'($urandom_range(0, 3));
        data_byte <= 8'($urandom_range(0, 255));
      end
    end
  end

  // Monitor: check the result word of the last cycle, then log the word taken now.
  always @(posedge clk) begin
    ring_result_t want;
    if (rst) begin
      word_taken = 1'b0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: result word with none expected, got byte %0h valid %0b dropped %0b",
                   $time, read_byte, read_valid, dropped_oldest);
        end else begin
          want = expected_results.pop_front();
          if (read_byte !== want.data) report_mismatch("read_byte", want.data, read_byte);
          if (read_valid !== want.valid) report_mismatch("read_valid", want.valid, read_valid);
          if (dropped_oldest !== want.dropped)
            report_mismatch("dropped_oldest", want.dropped, dropped_oldest);
        end
      end
      word_taken = start && !busy;
      if (word_taken) expected_results.push_back(log_ring_apply(mode_t'(mode), data_byte));
    end
  end

  initial begin : run_control
    int appends;
    int r;

    // Empty ring, a few appends, reads and pops, including a cursor left behind the oldest byte.
    push_cmd(MODE_POP, 8'h00);
    push_cmd(MODE_READ, 8'hFF);
    push_cmd(MODE_REWIND, 8'h81);
    push_cmd(MODE_APPEND, 8'h00);
    push_cmd(MODE_APPEND, 8'hFF);
    push_cmd(MODE_APPEND, 8'hA5);
    push_cmd(MODE_APPEND, 8'h5A);
    push_cmd(MODE_READ, 8'h00);
    push_cmd(MODE_READ, 8'h7E);
    push_cmd(MODE_POP, 8'hFF);
    push_cmd(MODE_POP, 8'h01);
    push_cmd(MODE_POP, 8'h80);
    push_cmd(MODE_READ, 8'h00);
    push_cmd(MODE_READ, 8'h00);
    push_cmd(MODE_READ, 8'hC3);
    push_cmd(MODE_REWIND, 8'h00);
    push_cmd(MODE_READ, 8'h3C);
    push_cmd(MODE_POP, 8'h00);
    push_cmd(MODE_POP, 8'hFF);
    push_cmd(MODE_READ, 8'hAA);
    push_cmd(MODE_APPEND, 8'h3C);
    push_cmd(MODE_REWIND, 8'hFF);
    push_cmd(MODE_READ, 8'h55);

    // Fill past capacity with no pops, so the ring wraps and drops bytes.
    appends = 0;
    while (appends < FILL_APPENDS) begin
      r = $urandom_range(0, 99);
      if (r < 92) begin
        push_cmd(MODE_APPEND, pick_byte());
        appends++;
      end else if (r < 98) begin
        push_cmd(MODE_READ, pick_byte());
      end else begin
        push_cmd(MODE_REWIND, pick_byte());
      end
    end

    // Near-full ring with every operation; rewinds followed by drops drag the cursor.
    for (int i = 0; i < MIXED_WORDS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) push_cmd(MODE_APPEND, pick_byte());
      else if (r < 65) push_cmd(MODE_READ, pick_byte());
      else if (r < 80) push_cmd(MODE_REWIND, pick_byte());
      else push_cmd(MODE_POP, pick_byte());
    end
    total_words = cmd_queue.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (cmd_queue.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #200us;
    $display("TB_ERROR");
    $finish;
  end

endmodule
